// File: hw/rtl/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int CAP_W           = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [31:0] MISS_VALUE     = 32'hFFFF_FFFF;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} lkv_in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
	} lkv_out_t;

	typedef enum logic {
		KIND_GET = 1'b0,
		KIND_PUT = 1'b1
	} lkv_kind_t;

	// update broadcast from the controller to every cell
	typedef struct packed {
		logic look;
		logic en;
		logic hit;
		logic evict;
		logic put;
	} lkv_upd_t;

endpackage

`default_nettype wire

// File: hw/rtl/lkv_cell.sv
`default_nettype none

module lkv_cell #(
	parameter int IDX  = 0,
	parameter int CW   = 5,
	parameter int RW   = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lkv_pkg::lkv_upd_t     upd,
	input  wire  [31:0]           cmd_key,
	input  wire  [31:0]           cmd_value,
	input  wire  [CW-1:0]         count,
	input  wire  [CW-1:0]         old_rank,
	output logic                  match,
	output logic [RW-1:0]         rank,
	output logic [31:0]           value
);
	import lkv_pkg::*;

	logic [31:0]   key_q;
	logic [31:0]   value_q;
	logic          valid_q;
	logic [RW-1:0] rank_q;
	logic          match_q;
	logic          target;
	logic          older;

	assign match = valid_q && (key_q == cmd_key);
	assign rank  = rank_q;
	assign value = value_q;

	always_comb begin
		if (upd.hit) begin
			target = match_q;
		end else if (upd.evict) begin
			target = valid_q && (CW'(rank_q) == (count - CW'(1)));
		end else begin
			target = (CW'(IDX) == count);
		end
		older = valid_q && (CW'(rank_q) < old_rank);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
			match_q <= 1'b0;
		end else begin
			if (upd.look) begin
				match_q <= match;
			end
			if (upd.en) begin
				if (target) begin
					valid_q <= 1'b1;
					rank_q  <= '0;
				end else if (older) begin
					rank_q <= rank_q + RW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && target) begin
			if (upd.put) begin
				value_q <= cmd_value;
			end
			if (!upd.hit) begin
				key_q <= cmd_key;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lru_key_value_cache.sv
`default_nettype none
// lru_key_value_cache: fully associative key-value store, lru replacement.
// command channel: cmd is taken at a rising edge with start high and busy
// low; cmd.kind selects get or put. busy stays high until the block can
// take the next command.
// result channel: done is high for exactly one cycle with result holding
// hit, read_value and evicted; the receiver cannot stall, so the beat is
// taken in that cycle.
// timing: a command passes through capture, key compare across all cells
// with registered gather of the matching rank and value, and update of
// the cells on a hit or a put. done is registered at the end of the update
// step; the next command may be accepted at the edge where the beat is
// taken, and not before the last command is through.
// configuration: cfg_we writes cfg_wdata as the capacity, zero acting as
// one and values above MAX_ENTRIES saturating; write only while idle.
// reset: all entries invalid, count zero, capacity sixteen; no clearing
// pass, the block accepts a command in the first cycle after reset.
module lru_key_value_cache #(
	parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire  [lkv_pkg::CAP_W-1:0] cfg_wdata,
	input  wire                       start,
	output logic                      busy,
	input  lkv_pkg::lkv_in_t          cmd,
	output logic                      done,
	output lkv_pkg::lkv_out_t         result
);
	import lkv_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t         state_q;
	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]  count_q;
	lkv_in_t        cmd_q;
	logic           hit_q;
	logic           evict_q;
	logic [CW-1:0]  old_rank_q;
	logic [31:0]    rdval_q;
	lkv_out_t       result_q;
	logic           done_q;

	logic [MAX_ENTRIES-1:0] match;
	logic [RW-1:0]          rank  [MAX_ENTRIES];
	logic [31:0]            value [MAX_ENTRIES];
	logic [RW-1:0]          sel_rank;
	logic [31:0]            sel_value;
	logic                   any_hit;
	logic [CW-1:0]          limit;
	logic                   evict_now;
	lkv_upd_t               upd;

	always_comb begin
		sel_rank  = '0;
		sel_value = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			sel_rank  = sel_rank  | (match[i] ? rank[i]  : '0);
			sel_value = sel_value | (match[i] ? value[i] : '0);
		end
		any_hit = |match;
		if (cap_q == '0) begin
			limit = CW'(1);
		end else if (int'(cap_q) > MAX_ENTRIES) begin
			limit = CW'(MAX_ENTRIES);
		end else begin
			limit = CW'(cap_q);
		end
		evict_now = (cmd_q.kind == KIND_PUT) && !any_hit && (count_q >= limit);
	end

	always_comb begin
		upd.look  = (state_q == ST_LOOK);
		upd.en    = (state_q == ST_UPD) && (hit_q || (cmd_q.kind == KIND_PUT));
		upd.hit   = hit_q;
		upd.evict = evict_q;
		upd.put   = (cmd_q.kind == KIND_PUT);
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		lkv_cell #(
			.IDX (g),
			.CW  (CW),
			.RW  (RW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.upd       (upd),
			.cmd_key   (cmd_q.key),
			.cmd_value (cmd_q.value),
			.count     (count_q),
			.old_rank  (old_rank_q),
			.match     (match[g]),
			.rank      (rank[g]),
			.value     (value[g])
		);
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CAP_RESET;
			count_q <= '0;
			hit_q   <= 1'b0;
			evict_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					hit_q   <= any_hit;
					evict_q <= evict_now;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if ((cmd_q.kind == KIND_PUT) && !hit_q && !evict_q) begin
						count_q <= count_q + CW'(1);
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_LOOK) begin
			if (any_hit) begin
				old_rank_q <= CW'(sel_rank);
			end else if (evict_now) begin
				old_rank_q <= count_q - CW'(1);
			end else begin
				old_rank_q <= count_q;
			end
			rdval_q <= (any_hit && cmd_q.kind == KIND_GET) ? sel_value : MISS_VALUE;
		end
		if (state_q == ST_UPD) begin
			result_q.hit        <= hit_q;
			result_q.read_value <= rdval_q;
			result_q.evicted    <= evict_q;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lkv_checker.sv
`default_nettype none

module lkv_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       start,
	input wire                       busy,
	input wire                       done,
	input lkv_pkg::lkv_out_t         result
);
	import lkv_pkg::*;

	// an accepted beat keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// a result only follows a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in flight");

	// one result per command, never two beats in a row
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats in a row");

	// an eviction only comes with a missing key
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.evicted |-> !result.hit && result.read_value == MISS_VALUE)
		else $error("eviction reported with a hit or a read value");

	// busy is low while the result beat is shown
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high while the result is shown");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire

// File: tb/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
	import lkv_pkg::*;

	localparam int SLOTS = MAX_ENTRIES_DEF;
	localparam int QUIET_LIMIT = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_PHASES = 12;
	localparam int OPS_PER_PHASE = 94;
	localparam logic [CAP_W-1:0] CAP_TOP = '1;

	class cache_tracker;
		logic [31:0] keys[SLOTS];
		logic [31:0] vals[SLOTS];
		bit valid[SLOTS];
		int unsigned age[SLOTS];
		int unsigned used;
		logic [CAP_W-1:0] capacity;
		lkv_out_t expected_q[$];
		int fail_count;

		function new();
			capacity = CAP_RESET;
			used = 0;
			fail_count = 0;
			foreach (valid[i]) begin
				valid[i] = 1'b0;
				age[i] = 0;
				keys[i] = '0;
				vals[i] = '0;
			end
		endfunction

		function int unsigned entry_limit();
			if (capacity == 0)
				return 1;
			if (capacity > SLOTS)
				return SLOTS;
			return capacity;
		endfunction

		// every valid entry newer than the slot ages by one
		function void make_newest(int s, int unsigned old_age);
			foreach (valid[i])
				if (i != s && valid[i] && age[i] < old_age)
					age[i]++;
			age[s] = 0;
		endfunction

		function void note_op(lkv_in_t op);
			lkv_out_t r;
			int s;
			s = -1;
			r.hit = 1'b0;
			r.read_value = MISS_VALUE;
			r.evicted = 1'b0;
			foreach (valid[i])
				if (s < 0 && valid[i] && keys[i] == op.key)
					s = i;
			if (s >= 0) begin
				r.hit = 1'b1;
				make_newest(s, age[s]);
				if (op.kind == KIND_GET)
					r.read_value = vals[s];
				else
					vals[s] = op.value;
			end else if (op.kind == KIND_PUT) begin
				if (used >= entry_limit()) begin
					foreach (valid[i])
						if (valid[i] && (s < 0 || age[i] > age[s]))
							s = i;
					if (s < 0)
						s = 0;
					r.evicted = 1'b1;
					make_newest(s, age[s]);
				end else begin
					foreach (valid[i])
						if (s < 0 && !valid[i])
							s = i;
					if (s < 0)
						s = 0;
					make_newest(s, used);
					valid[s] = 1'b1;
					used++;
				end
				keys[s] = op.key;
				vals[s] = op.value;
			end
			expected_q.insert(expected_q.size(), r);
		endfunction

		task report(string msg);
			if (fail_count < 40)
				$display("%0t mismatch: %s", $realtime, msg);
			fail_count++;
		endtask

		task check_result(lkv_out_t got);
			lkv_out_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result beat with nothing pending: hit %b value %h evicted %b",
					got.hit, got.read_value, got.evicted));
				return;
			end
			want = expected_q.pop_front();
			if (got.hit !== want.hit)
				report($sformatf("hit %b, want %b", got.hit, want.hit));
			if (got.read_value !== want.read_value)
				report($sformatf("read_value %h, want %h", got.read_value, want.read_value));
			if (got.evicted !== want.evicted)
				report($sformatf("evicted %b, want %b", got.evicted, want.evicted));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic start;
	logic busy;
	lkv_in_t cmd;
	logic done;
	lkv_out_t result;

	cache_tracker tracker;
	int quiet_cycles;

	lru_key_value_cache i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result beat is checked before the command beat of the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_result(result);
			if (start && !busy)
				tracker.note_op(cmd);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL lru_key_value_cache");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic issue(input lkv_kind_t kind, input logic [31:0] key,
		input logic [31:0] value, input int gap);
		lkv_in_t op;
		op.kind = kind;
		op.key = key;
		op.value = value;
		cmd <= op;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (tracker.expected_q.size() != 0 || busy);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.capacity = cap;
	endtask

	function automatic int draw_gap(input bit steady);
		return steady ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 15))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		logic [CAP_W-1:0] phase_caps[RANDOM_PHASES];
		logic [31:0] pool[$];
		logic [31:0] key;
		int eff;
		int pool_size;
		bit steady;

		tracker = new();
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty store, extreme keys and values, update of a present key
		issue(KIND_GET, 32'h0000_0000, 32'h1234_5678, draw_gap(0));
		issue(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF, draw_gap(0));
		issue(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		issue(KIND_PUT, 32'h0000_0000, 32'h0000_0000, 0);
		issue(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, draw_gap(0));
		issue(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF, 0);
		issue(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000, draw_gap(0));
		issue(KIND_GET, 32'hFFFF_FFFF, 32'h5555_AAAA, 0);
		issue(KIND_PUT, 32'h0000_0000, 32'hA5A5_5A5A, draw_gap(0));
		issue(KIND_GET, 32'h0000_0000, 32'h0000_0000, 0);
		issue(KIND_GET, 32'h0000_0001, 32'h0000_0000, draw_gap(0));

		// capacity lowered below the entry count
		set_capacity(5'd2);
		issue(KIND_PUT, 32'h0000_1234, 32'h0BAD_F00D, 0);
		issue(KIND_PUT, 32'h0000_5678, 32'hFEED_0001, 0);
		issue(KIND_GET, 32'h8000_0000, 32'h0000_0000, draw_gap(0));

		// zero capacity acts as one
		set_capacity(5'd0);
		issue(KIND_PUT, 32'h0000_000A, 32'h0000_0001, 0);
		issue(KIND_PUT, 32'h0000_000B, 32'h0000_0002, draw_gap(0));
		issue(KIND_GET, 32'h0000_000A, 32'h0000_0000, 0);
		issue(KIND_GET, 32'h0000_000B, 32'h0000_0000, draw_gap(0));

		phase_caps = '{CAP_TOP, 5'd16, 5'd1, 5'd3, 5'd17, 5'd0,
			5'd8, 5'd16, 5'd2, 5'd15, 5'd0, 5'd0};
		phase_caps[RANDOM_PHASES-2] = CAP_W'($urandom_range(0, 31));
		phase_caps[RANDOM_PHASES-1] = CAP_W'($urandom_range(0, 31));

		foreach (phase_caps[p]) begin
			set_capacity(phase_caps[p]);
			eff = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p];
			pool_size = eff + $urandom_range(0, 8);
			if ($urandom_range(0, 4) == 0)
				pool_size = $urandom_range(1, 4);
			pool.delete();
			repeat (pool_size)
				pool.insert(pool.size(), pick_key());
			steady = ($urandom_range(0, 3) == 0);
			repeat (OPS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0)
					key = $urandom();
				else
					key = pool[$urandom_range(0, pool.size() - 1)];
				issue(($urandom_range(0, 99) < 55) ? KIND_PUT : KIND_GET, key, $urandom(),
					draw_gap(steady));
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.fail_count == 0)
			$display("PASS lru_key_value_cache");
		else
			$display("FAIL lru_key_value_cache");
		$finish;
	end

endmodule
